### src/fcte_pkg.sv
// ----------------------------------------------------------------------------
// fcte_pkg: shared types and constants of the cluster table engine
// request kinds, status codes, entry marks and the front-to-back request
// ----------------------------------------------------------------------------
`default_nettype none
package fcte_pkg;
    localparam int unsigned TABLE_DEPTH_DEF = 4096;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned ENTRY_W = 28;
    localparam logic [11:0] COUNT_RESET = 12'd4094;
    localparam logic [27:0] END_OF_CHAIN = 28'hFFFFFFF;
    localparam logic [27:0] END_MARK_LOW = 28'hFFFFFF8;
    localparam logic [27:0] MIN_CLUSTER = 28'd2;

    // register index of the cluster count
    localparam logic [1:0] REG_COUNT = 2'd0;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_SET    = 2'd1,
        K_ALLOC  = 2'd2,
        K_FREE   = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LOOP = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [27:0] cluster;
        logic [27:0] value;
        logic        in_range;
    } t_req;
endpackage
`default_nettype wire

### src/fcte_front.sv
// ----------------------------------------------------------------------------
// fcte_front: request intake, range check and two-entry request queue
// classifies each item against the cluster limit and queues it for the back
// ----------------------------------------------------------------------------
`default_nettype none
module fcte_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_kind,
    input  wire logic [27:0]          i_cluster,
    input  wire logic [27:0]          i_value,
    input  wire logic [27:0]          i_limit,
    output logic                      o_req_valid,
    input  wire logic                 i_req_ready,
    output fcte_pkg::t_req            o_req
);
    import fcte_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       n_req;
    logic       w_push, w_pop;

    // classify the incoming item
    always_comb begin
        n_req.kind     = t_kind'(i_kind);
        n_req.cluster  = i_cluster;
        n_req.value    = i_value;
        n_req.in_range = (i_cluster >= MIN_CLUSTER) && (i_cluster < i_limit);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign w_pop       = o_req_valid && i_req_ready;
    assign o_req       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_req;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

### src/fcte_back.sv
// ----------------------------------------------------------------------------
// fcte_back: table memory and operation sequencer
// runs lookup, set, allocate scan and free walk on the table, with a
// clearing pass over the memory after reset
// ----------------------------------------------------------------------------
`default_nettype none
module fcte_back #(
    parameter int unsigned TABLE_DEPTH = fcte_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  fcte_pkg::t_req       i_req,
    input  wire logic [27:0]     i_limit,
    input  wire logic [11:0]     i_count,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [1:0]           o_status,
    output logic [27:0]          o_result_cluster
);
    import fcte_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_ALLOC, S_FREE, S_OUT
    } t_state;

    logic [27:0] r_mem [TABLE_DEPTH];
    logic [27:0] r_rdata;
    t_state      r_state;
    t_req        r_req;
    logic [27:0] r_c;
    logic [11:0] r_steps;
    logic [AW:0] r_clr;
    logic [1:0]  r_status;
    logic [27:0] r_result;
    logic        r_rd_wait;

    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [27:0] w_wdata;
    logic        w_c_ok;

    assign o_req_ready      = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_result_cluster = r_result;
    assign w_c_ok           = (r_c >= MIN_CLUSTER) && (r_c < i_limit);
    assign w_raddr          = (r_state == S_IDLE) ? i_req.cluster[AW-1:0]
                                                  : r_c[AW-1:0];

    // write port select
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_c[AW-1:0];
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr[AW-1:0];
            end
            S_ALLOC: begin
                w_we    = !r_rd_wait && (r_rdata == '0) && w_c_ok;
                w_wdata = END_OF_CHAIN;
            end
            S_FREE: begin
                w_we = !r_rd_wait && w_c_ok && (r_steps < i_count)
                       && (r_c < END_MARK_LOW);
            end
            S_READ: begin
                w_we    = (r_req.kind == K_SET) && r_req.in_range;
                w_waddr = r_req.cluster[AW-1:0];
                w_wdata = r_req.value;
            end
            default: ;
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(TABLE_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req     <= i_req;
                        r_status  <= ST_OK;
                        r_result  <= '0;
                        r_steps   <= '0;
                        r_rd_wait <= 1'b1;
                        case (i_req.kind)
                            K_ALLOC: begin
                                r_c     <= MIN_CLUSTER;
                                r_state <= S_ALLOC;
                            end
                            K_FREE: begin
                                r_c     <= i_req.cluster;
                                r_state <= S_FREE;
                            end
                            default: r_state <= S_READ;
                        endcase
                    end
                end
                S_READ: begin
                    if (r_req.kind == K_LOOKUP)
                        r_result <= r_req.in_range ? r_rdata : END_OF_CHAIN;
                    else if (!r_req.in_range)
                        r_status <= ST_RANGE;
                    r_state <= S_OUT;
                end
                // one read per cluster, next read issued after evaluation
                S_ALLOC: begin
                    if (r_rd_wait) begin
                        r_rd_wait <= 1'b0;
                    end else if (!w_c_ok) begin
                        r_state <= S_OUT;
                    end else if (r_rdata == '0) begin
                        r_result <= r_c;
                        r_state  <= S_OUT;
                    end else begin
                        r_c       <= r_c + 1'b1;
                        r_rd_wait <= 1'b1;
                    end
                end
                S_FREE: begin
                    if (r_rd_wait) begin
                        r_rd_wait <= 1'b0;
                    end else if (r_c < MIN_CLUSTER || r_c >= END_MARK_LOW) begin
                        r_state <= S_OUT;
                    end else if (!w_c_ok) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_OUT;
                    end else if (r_steps >= i_count) begin
                        r_status <= ST_LOOP;
                        r_state  <= S_OUT;
                    end else begin
                        r_c       <= r_rdata;
                        r_steps   <= r_steps + 1'b1;
                        r_rd_wait <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/fat_cluster_table_engine.sv
// ----------------------------------------------------------------------------
// fat_cluster_table_engine: on-chip FAT32 cluster allocation table
// front queues classified items, back runs them on the table memory
// ----------------------------------------------------------------------------
// operation: lookup and set finish in the read state and then present the result; allocate
//   reads and checks each scanned cluster in turn, free each chain link, paced by the single memory read port
// flow: one item at a time in the back; the next is taken only after the output handshake
// reset: synchronous; a clearing pass over all TABLE_DEPTH entries (4096 by default)
//   zeroes the table before the first item runs; cluster_count resets to 4094
`default_nettype none
module fat_cluster_table_engine #(
    parameter int unsigned TABLE_DEPTH = fcte_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [27:0] i_cluster,
    input  wire logic [27:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [27:0]      o_result_cluster,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fcte_pkg::*;

    logic [11:0] r_count;
    logic [27:0] w_limit;
    logic        w_req_valid, w_req_ready;
    t_req        w_req;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (psel && penable && pwrite && paddr == REG_COUNT) begin
            r_count <= pwdata[11:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_COUNT) ? {20'd0, r_count} : 32'd0;

    // exclusive cluster limit, capped at the table depth
    assign w_limit = ({16'd0, r_count} + 28'd2 > 28'(TABLE_DEPTH)) ? 28'(TABLE_DEPTH)
                                                                 : {16'd0, r_count} + 28'd2;

    fcte_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_cluster, .i_value,
        .i_limit(w_limit), .o_req_valid(w_req_valid), .i_req_ready(w_req_ready),
        .o_req(w_req)
    );

    fcte_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(w_req_valid), .o_req_ready(w_req_ready),
        .i_req(w_req), .i_limit(w_limit), .i_count(r_count), .o_valid, .i_ready,
        .o_status, .o_result_cluster
    );
endmodule
`default_nettype wire
